// ----- hw/rtl/ifrb_pkg.sv -----
// Package for the IP flood rate blocker: shared types, codes and reset values.
// No dependencies.
`default_nettype none
package ifrb_pkg;
  localparam int DEF_TABLE_DEPTH = 1024;
  localparam int DEF_COUNT_BITS = 16;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 41;

  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_BLOCK_TIME = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_SYN_TH = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_ICMP_TH = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_UDP_TH = 3'd4;

  localparam logic [40:0] RST_WINDOW = 41'd1000000000;
  localparam logic [40:0] RST_BLOCK_TIME = 41'd30000000000;
  localparam logic [15:0] RST_SYN_TH = 16'd100;
  localparam logic [15:0] RST_ICMP_TH = 16'd50;
  localparam logic [15:0] RST_UDP_TH = 16'd200;

  localparam logic [2:0] RSN_NONE = 3'd0;
  localparam logic [2:0] RSN_BLOCKED = 3'd1;
  localparam logic [2:0] RSN_NULL = 3'd2;
  localparam logic [2:0] RSN_XMAS = 3'd3;
  localparam logic [2:0] RSN_FIN = 3'd4;
  localparam logic [2:0] RSN_SYN = 3'd5;
  localparam logic [2:0] RSN_ICMP = 3'd6;
  localparam logic [2:0] RSN_UDP = 3'd7;

  // Rate table selector.
  localparam logic [1:0] TBL_NONE = 2'd0;
  localparam logic [1:0] TBL_SYN = 2'd1;
  localparam logic [1:0] TBL_ICMP = 2'd2;
  localparam logic [1:0] TBL_UDP = 2'd3;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;
  localparam logic [7:0] ICMP_PING = 8'd8;

  // Classified command passed from front to back.
  typedef struct packed {
    logic        manual;     // manual block insert
    logic        bypass;     // no table touched, pass
    logic        l4_ok;
    logic [2:0]  scan_rsn;   // nonzero: scan drop after block check
    logic [1:0]  tbl;        // rate table to count in
    logic [63:0] now;
    logic [31:0] ip;
  } cmd_t;
endpackage
`default_nettype wire

// ----- hw/rtl/ip_flood_rate_blocker.sv -----
// Top level of the IP flood rate blocker: config registers, front and back parts.
// Depends on ifrb_pkg, ifrb_front and ifrb_back.
//
//   Channel   Handshake                  Payload
//   command   start / busy               action, now_ns, src_ip, ... icmp_type
//   verdict   done strobe, one cycle     drop, verdict_reason
//   config    cfg_valid / cfg_ready      cfg_index, cfg_data
//
// In the back part each item is worked in order: dequeue with memory read, read
// data arrival, then verdict and table write. Due to the memory read-modify-write,
// the next item is dequeued only after the last one is written. A two-entry queue
// lets commands arrive while one is worked. Reset is synchronous; afterwards the
// back part wipes the tags of all TABLE_DEPTH entries (1024 by default) while the
// queue fills and then raises busy. The verdict cannot be stalled.
`default_nettype none
module ip_flood_rate_blocker #(
  parameter int TABLE_DEPTH = ifrb_pkg::DEF_TABLE_DEPTH,
  parameter int COUNT_BITS = ifrb_pkg::DEF_COUNT_BITS
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic                                 action,
  input  wire logic [63:0]                          now_ns,
  input  wire logic [31:0]                          src_ip,
  input  wire logic                                 ipv4_complete,
  input  wire logic [7:0]                           ip_protocol,
  input  wire logic                                 l4_complete,
  input  wire logic [5:0]                           tcp_flags,
  input  wire logic [7:0]                           icmp_type,
  output logic                                      done,
  output logic                                      drop,
  output logic [2:0]                                verdict_reason,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [ifrb_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  wire logic [ifrb_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import ifrb_pkg::*;

  logic [40:0] win_span, hold_span;
  logic [15:0] syn_th, icmp_th, udp_th;
  logic pop, q_valid;
  cmd_t q_cmd;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      win_span <= RST_WINDOW;
      hold_span <= RST_BLOCK_TIME;
      syn_th <= RST_SYN_TH;
      icmp_th <= RST_ICMP_TH;
      udp_th <= RST_UDP_TH;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WINDOW: win_span <= cfg_data;
        REG_BLOCK_TIME: hold_span <= cfg_data;
        REG_SYN_TH: syn_th <= cfg_data[15:0];
        REG_ICMP_TH: icmp_th <= cfg_data[15:0];
        REG_UDP_TH: udp_th <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  ifrb_front u_front (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action),
    .now_ns(now_ns), .src_ip(src_ip), .ipv4_complete(ipv4_complete),
    .ip_protocol(ip_protocol), .l4_complete(l4_complete), .tcp_flags(tcp_flags),
    .icmp_type(icmp_type), .pop(pop), .q_valid(q_valid), .q_cmd(q_cmd)
  );

  ifrb_back #(.TABLE_DEPTH(TABLE_DEPTH), .COUNT_BITS(COUNT_BITS)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_cmd(q_cmd), .pop(pop),
    .win_span(win_span), .hold_span(hold_span), .syn_th(syn_th),
    .icmp_th(icmp_th), .udp_th(udp_th), .done(done), .drop(drop),
    .verdict_reason(verdict_reason)
  );
endmodule
`default_nettype wire

// ----- hw/rtl/ifrb_front.sv -----
// Front part: takes commands, classifies the header, pushes into a two-entry queue.
// Depends on ifrb_pkg.
`default_nettype none
module ifrb_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              action,
  input  wire logic [63:0]       now_ns,
  input  wire logic [31:0]       src_ip,
  input  wire logic              ipv4_complete,
  input  wire logic [7:0]        ip_protocol,
  input  wire logic              l4_complete,
  input  wire logic [5:0]        tcp_flags,
  input  wire logic [7:0]        icmp_type,
  input  wire logic              pop,
  output logic                   q_valid,
  output ifrb_pkg::cmd_t         q_cmd
);
  import ifrb_pkg::*;

  cmd_t q_mem [2];
  logic rd_ptr, wr_ptr;
  logic [1:0] fill;
  cmd_t cls;
  logic push;

  // Header classification.
  always_comb begin
    cls = '0;
    cls.manual = action;
    cls.bypass = !action && !ipv4_complete;
    cls.l4_ok = l4_complete;
    cls.now = now_ns;
    cls.ip = src_ip;
    cls.scan_rsn = RSN_NONE;
    cls.tbl = TBL_NONE;
    if (ip_protocol == PROTO_TCP) begin
      if (tcp_flags == 6'd0) begin
        cls.scan_rsn = RSN_NULL;
      end else if (tcp_flags[0] && tcp_flags[3] && tcp_flags[5]) begin
        cls.scan_rsn = RSN_XMAS;
      end else if (tcp_flags[0] && !tcp_flags[4]) begin
        cls.scan_rsn = RSN_FIN;
      end else if (tcp_flags[1] && !tcp_flags[4]) begin
        cls.tbl = TBL_SYN;
      end
    end else if (ip_protocol == PROTO_ICMP) begin
      if (icmp_type == ICMP_PING) cls.tbl = TBL_ICMP;
    end else if (ip_protocol == PROTO_UDP) begin
      cls.tbl = TBL_UDP;
    end else begin
      cls.l4_ok = 1'b1;
    end
  end

  assign busy = fill[1];
  assign push = start && !busy;
  assign q_valid = (fill != 2'd0);
  assign q_cmd = q_mem[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) q_mem[wr_ptr] <= cls;
  end

  // Queue pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/ifrb_back.sv -----
// Back part: blocklist and rate table read-modify-write, verdict strobe.
// Depends on ifrb_pkg.
`default_nettype none
module ifrb_back #(
  parameter int TABLE_DEPTH = ifrb_pkg::DEF_TABLE_DEPTH,
  parameter int COUNT_BITS = ifrb_pkg::DEF_COUNT_BITS
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             q_valid,
  input  wire ifrb_pkg::cmd_t   q_cmd,
  output logic                  pop,
  input  wire logic [40:0]      win_span,
  input  wire logic [40:0]      hold_span,
  input  wire logic [15:0]      syn_th,
  input  wire logic [15:0]      icmp_th,
  input  wire logic [15:0]      udp_th,
  output logic                  done,
  output logic                  drop,
  output logic [2:0]            verdict_reason
);
  import ifrb_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  // Sequencer: CLEAR (tag wipe after reset), IDLE, READ (memory read in flight),
  // WRITE (verdict and update).
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_WRITE = 2'd2;
  localparam logic [1:0] S_CLEAR = 2'd3;

  logic [1:0] state;
  logic [IW-1:0] clr_idx;
  cmd_t cur;
  logic [IW-1:0] slot;

  // Tags carry their valid bit on top; all tables live in memories.
  logic [32:0] btag_mem [TABLE_DEPTH];
  logic [63:0] bexp_mem [TABLE_DEPTH];
  logic bman_mem [TABLE_DEPTH];
  logic [32:0] rtag_mem [3][TABLE_DEPTH];
  logic [COUNT_BITS-1:0] rcnt_mem [3][TABLE_DEPTH];
  logic [63:0] rst_mem [3][TABLE_DEPTH];

  logic [32:0] btag_rd;
  logic [63:0] bexp_rd;
  logic bman_rd;
  logic [32:0] rtag_rd [3];
  logic [COUNT_BITS-1:0] rcnt_rd [3];
  logic [63:0] rstart_rd [3];

  assign slot = q_cmd.ip[IW-1:0];
  assign pop = (state == S_IDLE) && q_valid;

  // Registered memory reads, addressed from the queue head.
  always_ff @(posedge clk) begin
    if (pop) begin
      btag_rd <= btag_mem[slot];
      bexp_rd <= bexp_mem[slot];
      bman_rd <= bman_mem[slot];
      for (int t = 0; t < 3; t++) begin
        rtag_rd[t] <= rtag_mem[t][slot];
        rcnt_rd[t] <= rcnt_mem[t][slot];
        rstart_rd[t] <= rst_mem[t][slot];
      end
      cur <= q_cmd;
    end
  end

  // Decision logic for the item in the WRITE step.
  logic [IW-1:0] cslot;
  logic [32:0] cur_tag;
  logic bhit, bexpired;
  logic [64:0] exp_sum;
  logic [63:0] new_exp;
  logic [1:0] ti;
  logic rhit_tag, rwin_over, rcount_upd;
  logic [63:0] age;
  logic [COUNT_BITS-1:0] cnt_new;
  logic [15:0] thr;
  logic over;
  logic v_drop;
  logic [2:0] v_rsn;
  logic b_wr, b_clr, b_man;
  logic r_wr;

  assign cslot = cur.ip[IW-1:0];
  assign cur_tag = {1'b1, cur.ip};
  assign exp_sum = {1'b0, cur.now} + {24'd0, hold_span};
  assign new_exp = exp_sum[64] ? '1 : exp_sum[63:0];
  assign ti = cur.tbl - 2'd1;
  assign age = cur.now - rstart_rd[ti];

  always_comb begin
    bhit = (btag_rd == cur_tag);
    bexpired = bhit && !bman_rd && !(cur.now < bexp_rd);
    rhit_tag = (rtag_rd[ti] == cur_tag);
    rwin_over = age > {23'd0, win_span};
    rcount_upd = rhit_tag && !rwin_over;
    cnt_new = (rcnt_rd[ti] < CMAX) ? rcnt_rd[ti] + 1'b1 : rcnt_rd[ti];
    case (cur.tbl)
      TBL_SYN: thr = syn_th;
      TBL_ICMP: thr = icmp_th;
      default: thr = udp_th;
    endcase
    over = rcount_upd && ({{(32 - COUNT_BITS){1'b0}}, cnt_new} > {16'd0, thr});
    v_drop = 1'b0;
    v_rsn = RSN_NONE;
    b_wr = 1'b0;
    b_clr = 1'b0;
    b_man = 1'b0;
    r_wr = 1'b0;
    if (cur.manual) begin
      b_wr = 1'b1;
      b_man = 1'b1;
    end else if (cur.bypass) begin
      v_drop = 1'b0;
    end else if (bhit && !bexpired) begin
      v_drop = 1'b1;
      v_rsn = RSN_BLOCKED;
      b_wr = !bman_rd;
    end else begin
      b_clr = bexpired;
      if (!cur.l4_ok) begin
        v_drop = 1'b0;
      end else if (cur.scan_rsn != RSN_NONE) begin
        v_drop = 1'b1;
        v_rsn = cur.scan_rsn;
      end else if (cur.tbl != TBL_NONE) begin
        r_wr = 1'b1;
        if (over) begin
          v_drop = 1'b1;
          v_rsn = {1'b1, cur.tbl};
          b_wr = 1'b1;
          b_clr = 1'b0;
        end
      end
    end
  end

  // Table writes: tag wipe after reset, then updates in the WRITE step.
  always_ff @(posedge clk) begin
    if (state == S_CLEAR) begin
      btag_mem[clr_idx] <= '0;
      for (int t = 0; t < 3; t++) rtag_mem[t][clr_idx] <= '0;
    end else if (state == S_WRITE) begin
      if (b_wr) begin
        btag_mem[cslot] <= cur_tag;
        bexp_mem[cslot] <= b_man ? '1 : new_exp;
        bman_mem[cslot] <= b_man;
      end else if (b_clr) begin
        btag_mem[cslot] <= '0;
      end
      if (r_wr) begin
        rtag_mem[ti][cslot] <= cur_tag;
        rcnt_mem[ti][cslot] <= rcount_upd ? cnt_new : {{(COUNT_BITS - 1){1'b0}}, 1'b1};
        if (!rcount_upd) rst_mem[ti][cslot] <= cur.now;
      end
    end
  end

  // Control: state, clear index and result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_idx <= '0;
      done <= 1'b0;
      drop <= 1'b0;
      verdict_reason <= RSN_NONE;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (&clr_idx) state <= S_IDLE;
        end
        S_IDLE: if (pop) state <= S_READ;
        S_READ: state <= S_WRITE;
        S_WRITE: begin
          state <= S_IDLE;
          done <= 1'b1;
          drop <= v_drop;
          verdict_reason <= v_rsn;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- dv/ip_flood_rate_blocker_tb.sv -----
// Self-checking testbench for the IP flood rate blocker: drives packet beats and
// manual block commands, predicts each verdict and compares it. Depends on ifrb_pkg.
`default_nettype none
module ip_flood_rate_blocker_tb;
  import ifrb_pkg::*;

  localparam int DEPTH = DEF_TABLE_DEPTH;
  localparam logic [15:0] CNT_MAX = 16'hFFFF;
  localparam int LIMIT_CYCLES = 400000;
  localparam int RANDOM_ITEMS = 930;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 3'd7;

  typedef struct packed {
    logic        action;
    logic [63:0] now;
    logic [31:0] ip;
    logic        v4;
    logic [7:0]  proto;
    logic        l4;
    logic [5:0]  flags;
    logic [7:0]  itype;
  } pkt_t;

  typedef struct packed {
    logic       drop;
    logic [2:0] rsn;
  } verdict_t;

  // A directed row: stimulus plus an optional typed-in verdict.
  typedef struct packed {
    pkt_t     pkt;
    logic     fixed;
    verdict_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  pkt_t drv = '0;
  logic done, drop;
  logic [2:0] verdict_reason;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  ip_flood_rate_blocker dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .action(drv.action), .now_ns(drv.now), .src_ip(drv.ip),
    .ipv4_complete(drv.v4), .ip_protocol(drv.proto), .l4_complete(drv.l4),
    .tcp_flags(drv.flags), .icmp_type(drv.itype),
    .done(done), .drop(drop), .verdict_reason(verdict_reason),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: configuration and the four direct-mapped tables.
  logic [40:0] win_len, blk_len;
  logic [15:0] syn_lim, icmp_lim, udp_lim;
  logic [32:0] blk_tag [DEPTH];
  logic [63:0] blk_exp [DEPTH];
  logic        blk_man [DEPTH];
  logic [32:0] rt_tag [3][DEPTH];
  logic [15:0] rt_cnt [3][DEPTH];
  logic [63:0] rt_beg [3][DEPTH];

  verdict_t expected_verdicts[$];
  int mismatches = 0;
  int cycles = 0;
  logic [63:0] clock_ns = 64'd0;

  function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  // Count one packet in table t; returns 1 when the window count exceeds lim.
  function automatic logic count_over(int t, int slot, logic [32:0] tag,
                                      logic [63:0] now, logic [15:0] lim);
    if (rt_tag[t][slot] != tag || now - rt_beg[t][slot] > {23'd0, win_len}) begin
      rt_tag[t][slot] = tag;
      rt_cnt[t][slot] = 16'd1;
      rt_beg[t][slot] = now;
      return 1'b0;
    end
    if (rt_cnt[t][slot] < CNT_MAX) rt_cnt[t][slot] = rt_cnt[t][slot] + 16'd1;
    return rt_cnt[t][slot] > lim;
  endfunction

  function automatic verdict_t predict_verdict(pkt_t p);
    int slot;
    logic [32:0] tag;
    logic hit;
    verdict_t v;
    slot = p.ip % DEPTH;
    tag = {1'b1, p.ip};
    hit = 1'b0;
    v = '{1'b0, RSN_NONE};
    if (p.action) begin
      blk_tag[slot] = tag;
      blk_exp[slot] = '1;
      blk_man[slot] = 1'b1;
      return v;
    end
    if (!p.v4) return v;
    if (blk_tag[slot] == tag) begin
      if (blk_man[slot]) return '{1'b1, RSN_BLOCKED};
      if (p.now < blk_exp[slot]) begin
        blk_exp[slot] = sat_sum(p.now, {23'd0, blk_len});
        return '{1'b1, RSN_BLOCKED};
      end
      blk_tag[slot] = '0;
    end
    if (p.proto == PROTO_TCP) begin
      if (!p.l4) return v;
      if (p.flags == 6'd0) return '{1'b1, RSN_NULL};
      if (p.flags[0] && p.flags[3] && p.flags[5]) return '{1'b1, RSN_XMAS};
      if (p.flags[0] && !p.flags[4]) return '{1'b1, RSN_FIN};
      if (p.flags[1] && !p.flags[4]) begin
        hit = count_over(0, slot, tag, p.now, syn_lim);
        v.rsn = RSN_SYN;
      end
    end else if (p.proto == PROTO_ICMP) begin
      if (!p.l4) return v;
      if (p.itype == ICMP_PING) begin
        hit = count_over(1, slot, tag, p.now, icmp_lim);
        v.rsn = RSN_ICMP;
      end
    end else if (p.proto == PROTO_UDP) begin
      if (!p.l4) return v;
      hit = count_over(2, slot, tag, p.now, udp_lim);
      v.rsn = RSN_UDP;
    end
    if (hit) begin
      blk_tag[slot] = tag;
      blk_exp[slot] = sat_sum(p.now, {23'd0, blk_len});
      blk_man[slot] = 1'b0;
      v.drop = 1'b1;
    end else begin
      v.rsn = RSN_NONE;
    end
    return v;
  endfunction

  // Verdict checker: each strobed beat is compared with the oldest entry.
  always @(posedge clk) begin
    verdict_t w;
    cycles <= cycles + 1;
    if (!rst && done) begin
      if (expected_verdicts.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("Unexpected verdict beat: drop %0d reason %0d",
                                      drop, verdict_reason);
      end else begin
        w = expected_verdicts.pop_front();
        if (w.drop !== drop || w.rsn !== verdict_reason) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("Verdict mismatch: expected drop %0d reason %0d, got drop %0d reason %0d",
                     w.drop, w.rsn, drop, verdict_reason);
        end
      end
    end
  end

  // Timeout watchdog.
  always @(posedge clk) begin
    if (cycles > LIMIT_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  int burst_left = 0;

  // Send one beat, honoring bursts and gaps, and record its expected verdict.
  task automatic send_item(pkt_t p, logic fixed, verdict_t want);
    verdict_t v;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    v = predict_verdict(p);
    if (fixed && v != want)
      $display("Table row disagrees with prediction for ip %h", p.ip);
    drv <= p;
    start <= 1'b1;
    expected_verdicts.push_back(fixed ? want : v);
    do @(posedge clk); while (busy);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [40:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_WINDOW:     win_len = val;
      REG_BLOCK_TIME: blk_len = val;
      REG_SYN_TH:     syn_lim = val[15:0];
      REG_ICMP_TH:    icmp_lim = val[15:0];
      REG_UDP_TH:     udp_lim = val[15:0];
      default: ;
    endcase
  endtask

  function automatic pkt_t mk(logic act, logic [63:0] now, logic [31:0] ip,
                              logic [7:0] proto, logic [5:0] flags, logic [7:0] itype);
    return '{act, now, ip, 1'b1, proto, 1'b1, flags, itype};
  endfunction

  // Random packet: mostly flood traffic from a small pool of sources.
  function automatic pkt_t rand_pkt();
    pkt_t p;
    int k;
    k = $urandom_range(0, 99);
    if ($urandom_range(0, 19) == 0) clock_ns = clock_ns + {$urandom, $urandom};
    else clock_ns = clock_ns + $urandom_range(0, 40);
    p.now = clock_ns;
    if ($urandom_range(0, 49) == 0) p.now = {$urandom, $urandom};
    p.ip = ($urandom_range(0, 3) == 0) ? $urandom
         : {$urandom_range(0, 1) ? 22'h3FFFFF : 22'h0, 10'($urandom_range(0, 7))};
    p.action = (k < 3);
    p.v4 = ($urandom_range(0, 15) != 0);
    p.l4 = ($urandom_range(0, 15) != 0);
    p.flags = 6'($urandom);
    p.itype = $urandom_range(0, 1) ? ICMP_PING : 8'($urandom);
    if (k < 30) begin
      p.proto = PROTO_UDP;
    end else if (k < 55) begin
      p.proto = PROTO_TCP;
      if ($urandom_range(0, 2) != 0) p.flags = 6'b000010;
    end else if (k < 80) begin
      p.proto = PROTO_ICMP;
    end else begin
      p.proto = 8'($urandom);
    end
    return p;
  endfunction

  localparam int N_ROWS = 16;
  localparam logic [63:0] T_MAX = '1;
  row_t rows [N_ROWS];

  initial begin
    verdict_t none_v;
    none_v = '{1'b0, RSN_NONE};
    win_len = RST_WINDOW;
    blk_len = RST_BLOCK_TIME;
    syn_lim = RST_SYN_TH;
    icmp_lim = RST_ICMP_TH;
    udp_lim = RST_UDP_TH;
    for (int i = 0; i < DEPTH; i++) begin
      blk_tag[i] = '0; blk_exp[i] = '0; blk_man[i] = 1'b0;
      for (int t = 0; t < 3; t++) begin
        rt_tag[t][i] = '0; rt_cnt[t][i] = '0; rt_beg[t][i] = '0;
      end
    end
    rows[0]  = '{mk(1'b0, 64'd0, 32'h0, PROTO_TCP, 6'd0, 8'd0), 1'b1, '{1'b1, RSN_NULL}};
    rows[1]  = '{mk(1'b0, 64'd1, 32'hFFFFFFFF, PROTO_TCP, 6'b101001, 8'd0), 1'b1,
                 '{1'b1, RSN_XMAS}};
    rows[2]  = '{mk(1'b0, 64'd2, 32'h1, PROTO_TCP, 6'b000001, 8'd0), 1'b1, '{1'b1, RSN_FIN}};
    rows[3]  = '{mk(1'b0, 64'd3, 32'h2, PROTO_TCP, 6'b010001, 8'd0), 1'b1, none_v};
    rows[4]  = '{mk(1'b0, 64'd4, 32'h3, PROTO_TCP, 6'b000010, 8'd0), 1'b1, none_v};
    rows[5]  = '{mk(1'b0, 64'd5, 32'h4, PROTO_ICMP, 6'd0, ICMP_PING), 1'b1, none_v};
    rows[6]  = '{mk(1'b0, 64'd6, 32'h5, PROTO_UDP, 6'd0, 8'hFF), 1'b1, none_v};
    rows[7]  = '{mk(1'b0, 64'd7, 32'h6, 8'hFF, 6'd0, 8'd0), 1'b1, none_v};
    rows[8]  = '{mk(1'b1, 64'd8, 32'hC0A80001, 8'h0, 6'h3F, 8'd0), 1'b1, none_v};
    rows[9]  = '{mk(1'b0, 64'd9, 32'hC0A80001, PROTO_UDP, 6'd0, 8'd0), 1'b1,
                 '{1'b1, RSN_BLOCKED}};
    rows[10] = '{mk(1'b0, T_MAX, 32'hC0A80001, PROTO_TCP, 6'd0, 8'd0), 1'b1,
                 '{1'b1, RSN_BLOCKED}};
    // Same slot, different address: the tag does not match, so no block.
    rows[11] = '{mk(1'b0, 64'd10, 32'hC0A80401, PROTO_TCP, 6'd0, 8'd0), 1'b1,
                 '{1'b1, RSN_NULL}};
    rows[12] = '{'{1'b0, 64'd11, 32'hC0A80001, 1'b0, PROTO_TCP, 1'b1, 6'd0, 8'd0},
                 1'b1, none_v};
    rows[13] = '{'{1'b0, 64'd12, 32'h7, 1'b1, PROTO_TCP, 1'b0, 6'd0, 8'd0}, 1'b1, none_v};
    rows[14] = '{mk(1'b0, 64'd13, 32'h8, PROTO_ICMP, 6'd0, 8'd0), 1'b1, none_v};
    rows[15] = '{mk(1'b0, 64'd14, 32'h8, PROTO_ICMP, 6'd0, ICMP_PING), 1'b0, none_v};

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) send_item(rows[i].pkt, rows[i].fixed, rows[i].want);
    wait_idle();

    // Random phases across several register settings, extremes included.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_WINDOW, 41'd100); write_reg(REG_BLOCK_TIME, 41'd50);
          write_reg(REG_SYN_TH, 41'd3); write_reg(REG_ICMP_TH, 41'd2);
          write_reg(REG_UDP_TH, 41'd4);
        end
        1: begin
          write_reg(REG_WINDOW, 41'd0); write_reg(REG_BLOCK_TIME, 41'd0);
          write_reg(REG_SYN_TH, 41'd0); write_reg(REG_ICMP_TH, 41'd0);
          write_reg(REG_UDP_TH, 41'd0);
        end
        2: begin
          write_reg(REG_WINDOW, '1); write_reg(REG_BLOCK_TIME, '1);
          write_reg(REG_SYN_TH, 41'hFFFF); write_reg(REG_ICMP_TH, 41'hFFFE);
          write_reg(REG_UDP_TH, 41'd1);
        end
        3: begin
          write_reg(REG_WINDOW, 41'd1); write_reg(REG_BLOCK_TIME, 41'd1);
          write_reg(REG_SPARE, 41'h15555555555);
        end
        default: begin
          write_reg(REG_WINDOW, 41'($urandom_range(1, 400)));
          write_reg(REG_BLOCK_TIME, 41'({$urandom, $urandom} % 64'd300));
          write_reg(REG_SYN_TH, 41'($urandom_range(0, 6)));
          write_reg(REG_ICMP_TH, 41'($urandom_range(0, 6)));
          write_reg(REG_UDP_TH, 41'($urandom_range(0, 6)));
        end
      endcase
      for (int n = 0; n < RANDOM_ITEMS / 6; n++) send_item(rand_pkt(), 1'b0, none_v);
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- ip_flood_rate_blocker.f -----
hw/rtl/ifrb_pkg.sv
hw/rtl/ifrb_front.sv
hw/rtl/ifrb_back.sv
hw/rtl/ip_flood_rate_blocker.sv
dv/ip_flood_rate_blocker_tb.sv
